// ===== rtl/fskf_pkg.sv =====
// Package for the first-seen key filter: hash and key-split constants and
// the control state type. Used by the top level and the interfaces file.
// No dependencies.
package fskf_pkg;

	// Multiplicative hash constant; the home slot is the low bits of key * HASH_MULT.
	localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

	// Keys are split relative to this base into a package id and an entry index.
	localparam logic [31:0] KEY_BASE = 32'h8080_0000;
	localparam int unsigned ENTRY_BITS = 13;
	localparam int unsigned PKG_BITS   = 16;
	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned LIMIT_BITS = 8;
	localparam int unsigned KEY_BITS   = 32;

	// Input command codes.
	localparam logic CMD_OBSERVE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_TARGET_KEY   = 1'b0;
	localparam logic CFG_TARGET_LIMIT = 1'b1;

	// Reset value of the report limit.
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd8;

	// Control states of the filter.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/fskf_ifs.sv =====
// Valid/ready channel interfaces for the first-seen key filter: the
// observation input channel and the result output channel.
// Depends on fskf_pkg for field widths.
interface fskf_obs_if;
	import fskf_pkg::*;

	logic                cmd;
	logic [KEY_BITS-1:0] key;
	logic                accepting;
	logic                valid;
	logic                ready;

	modport source (output cmd, key, accepting, valid, input ready);
	modport sink (input cmd, key, accepting, valid, output ready);
endinterface

interface fskf_res_if;
	import fskf_pkg::*;

	logic                  report;
	logic                  target_hit;
	logic [COUNT_BITS-1:0] occurrence;
	logic [PKG_BITS-1:0]   package_id;
	logic [ENTRY_BITS-1:0] entry_index;
	logic                  valid;
	logic                  ready;

	modport source (output report, target_hit, occurrence, package_id, entry_index, valid,
		input ready);
	modport sink (input report, target_hit, occurrence, package_id, entry_index, valid,
		output ready);
endinterface

// ===== rtl/fskf_table_ram.sv =====
// Single-port-write, single-port-read synchronous RAM that holds the key table.
// Read data is registered. No dependencies.
module fskf_table_ram #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/first_seen_key_filter_unit.sv =====
// Top level of the first-seen key filter: control FSM, target counter,
// configuration registers, output register and the key table RAM.
// Depends on fskf_pkg, fskf_ifs (channel interfaces) and fskf_table_ram.
//
//   channel | dir | words                                   | handshake
//   --------+-----+-----------------------------------------+------------------
//   obs     | in  | cmd, key, accepting                     | valid/ready
//   res     | out | report, target_hit, occurrence,         | valid/ready
//           |     | package_id, entry_index                 |
//   cfg     | in  | cfg_we, cfg_index, cfg_wdata            | write on cfg_we
//
// One word is processed at a time. A word that needs no table lookup goes
// from idle straight to done; a table lookup reads the home slot in the
// hash state, then probes slots in turn (one RAM read per cycle) until the
// key or an empty slot is found or every slot is probed. A clear command
// writes every slot, one RAM write per slot. After reset the table is swept
// before the first word is taken. The result sits in an output register, so
// the next word is taken while it waits. TABLE_DEPTH must be a power of two.
module first_seen_key_filter_unit #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic clk,
	input  logic arst_n,
	fskf_obs_if.sink   obs,
	fskf_res_if.source res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);
	import fskf_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	state_t state_q, state_d;

	// Configuration registers.
	logic [KEY_BITS-1:0]   tkey_q;
	logic [LIMIT_BITS-1:0] tlim_q;

	// Item context and pending result.
	logic [KEY_BITS-1:0]   key_q;
	logic [AW-1:0]         slot_q;
	logic [AW-1:0]         probe_q;
	logic [AW-1:0]         clr_addr_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  rep_q;
	logic                  hit_q;
	logic [COUNT_BITS-1:0] occ_q;
	logic [PKG_BITS-1:0]   pkg_q;
	logic [ENTRY_BITS-1:0] idx_q;

	// Output register.
	logic                  res_valid_q;
	logic                  res_rep_q;
	logic                  res_hit_q;
	logic [COUNT_BITS-1:0] res_occ_q;
	logic [PKG_BITS-1:0]   res_pkg_q;
	logic [ENTRY_BITS-1:0] res_idx_q;

	// RAM controls.
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [KEY_BITS-1:0] ram_rdata;

	// Decoded control.
	logic                  take;
	logic                  load_out;
	logic                  hit_now;
	logic [KEY_BITS-1:0]   handle;
	logic [KEY_BITS-1:0]   hash_prod;
	logic [AW-1:0]         home_slot;
	logic [COUNT_BITS-1:0] count_inc;
	logic                  slot_found;
	logic                  slot_empty;
	logic                  probe_last;

	fskf_table_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (KEY_BITS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Per-word datapath terms. Only the low bits of the hash product are
	// needed, and they depend only on the low bits of the operands.
	assign take      = obs.valid && obs.ready;
	assign hit_now   = (obs.key == tkey_q);
	assign handle    = (obs.key >= KEY_BASE) ? (obs.key - KEY_BASE) : '0;
	assign hash_prod = key_q * HASH_MULT;
	assign home_slot = hash_prod[AW-1:0];
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign slot_found = (ram_rdata == key_q);
	assign slot_empty = (ram_rdata == '0);
	assign probe_last = (probe_q == '1);
	assign load_out   = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// Next state and RAM access control.
	always_comb begin
		state_d   = state_q;
		obs.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = key_q;
		ram_re    = 1'b0;
		ram_raddr = home_slot;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == '1) begin
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end
			end
			ST_IDLE: begin
				obs.ready = 1'b1;
				if (obs.valid) begin
					if (obs.cmd == CMD_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (obs.accepting && !hit_now && (obs.key != '0)) begin
						state_d = ST_HASH;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_HASH: begin
				ram_re    = 1'b1;
				ram_raddr = home_slot;
				state_d   = ST_PROBE;
			end
			ST_PROBE: begin
				if (slot_found) begin
					state_d = ST_DONE;
				end else if (slot_empty) begin
					ram_we  = 1'b1;
					state_d = ST_DONE;
				end else if (probe_last) begin
					state_d = ST_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = slot_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register, control counters and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			clr_addr_q <= '0;
			count_q    <= '0;
			tkey_q     <= '0;
			tlim_q     <= LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (take && obs.cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (take && obs.accepting && hit_now) begin
				count_q <= count_inc;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET_KEY:   tkey_q <= cfg_wdata;
					CFG_TARGET_LIMIT: tlim_q <= cfg_wdata[LIMIT_BITS-1:0];
					default:          tkey_q <= tkey_q;
				endcase
			end
		end
	end

	// Item context: captured on accept, result flag settled while probing.
	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= obs.key;
			rep_q <= 1'b0;
			occ_q <= '0;
			if (obs.cmd == CMD_CLEAR) begin
				hit_q <= 1'b0;
				pkg_q <= '0;
				idx_q <= '0;
			end else begin
				hit_q <= hit_now;
				pkg_q <= handle[ENTRY_BITS +: PKG_BITS];
				idx_q <= handle[ENTRY_BITS-1:0];
				if (obs.accepting && hit_now) begin
					occ_q <= count_inc;
					rep_q <= (count_inc <= {{(COUNT_BITS-LIMIT_BITS){1'b0}}, tlim_q});
				end
			end
		end
		if (state_q == ST_HASH) begin
			slot_q  <= home_slot;
			probe_q <= '0;
		end
		if (state_q == ST_PROBE) begin
			if (!slot_found && slot_empty) begin
				rep_q <= 1'b1;
			end
			slot_q  <= slot_q + 1'b1;
			probe_q <= probe_q + 1'b1;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			res_rep_q <= rep_q;
			res_hit_q <= hit_q;
			res_occ_q <= occ_q;
			res_pkg_q <= pkg_q;
			res_idx_q <= idx_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.report      = res_rep_q;
	assign res.target_hit  = res_hit_q;
	assign res.occurrence  = res_occ_q;
	assign res.package_id  = res_pkg_q;
	assign res.entry_index = res_idx_q;

`ifndef NO_ASSERTIONS
	// One word at a time: an accepted word closes the input for the next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !obs.ready)
		else $error("input taken while a word is in flight");

	// Table writes during probing never store the empty marker.
	a_no_zero_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == ST_PROBE) |-> (ram_wdata != '0))
		else $error("empty marker written as a key");

	// A reported target hit always carries a nonzero occurrence number.
	a_target_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.target_hit && res.report) |-> (res.occurrence != '0))
		else $error("reported target hit with zero occurrence");

	// A result is loaded only once the previous one has left or is leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res_valid_q) |-> res.ready)
		else $error("pending result overwritten");
`endif

endmodule
